>>> rtl/rbf_pkg.sv
// Package for the five-tap row box filter.
// Shared constants and the divide-by-five digit step; no dependencies.
`timescale 1ns / 1ps

package rbf_pkg;

   localparam int PIXEL_WIDTH_DEF = 8;
   localparam int TAPS            = 5;
   localparam int DIVISOR         = 5;
   // Quotient bits resolved by one divider stage, and the remainder width.
   localparam int DIV_DIGIT       = 4;
   localparam int REM_W           = 3;
   // Saturated per-row pixel count and its width.
   localparam int SEEN_W          = 2;
   localparam logic [SEEN_W-1:0] SEEN_MAX = 2'd2;
   // Offset of the last window position, the one that closes a row.
   localparam logic [1:0] LAST_OFFSET = 2'd2;
   // Command queue and result queue depths, as address widths.
   localparam int CMD_DEPTH_LOG2  = 2;
   localparam int RSP_DEPTH_LOG2  = 1;

   // Restoring long division by five over one digit of the dividend.
   // Returns the new remainder above the quotient digit.
   function automatic logic [REM_W+DIV_DIGIT-1:0] div5_step(
      input logic [REM_W-1:0]     rem_prev,
      input logic [DIV_DIGIT-1:0] digit
   );
      logic [REM_W:0]         part;
      logic [REM_W-1:0]       rem;
      logic [DIV_DIGIT-1:0]   quo;
      rem = rem_prev;
      quo = '0;
      for (int j = DIV_DIGIT - 1; j >= 0; j--) begin
         part = {rem, digit[j]};
         if (part >= (REM_W+1)'(DIVISOR)) begin
            part   = part - (REM_W+1)'(DIVISOR);
            quo[j] = 1'b1;
         end
         rem = part[REM_W-1:0];
      end
      return {rem, quo};
   endfunction

endpackage

>>> rtl/row_box_filter_5tap.sv
// Five-tap row box filter, top level.
// Instantiates rbf_front, rbf_back and two rbf_fifo queues; uses rbf_pkg.
`timescale 1ns / 1ps

// Usage:
//   Pixels enter on the req_ queue port: a transaction happens at a clock edge
//   with req_push high and req_full low. req_row_end marks the last pixel of
//   a row. Means leave on the rsp_ queue port: rsp_mean and rsp_last_of_row
//   show the oldest result while rsp_empty is low, and rsp_pop takes it.
//   The first two pixels of a row give no result; later pixels give one, and
//   a row end gives up to three, the final one with rsp_last_of_row set.
//   Throughput is one pixel per cycle along a row while results are popped. A
//   row end takes up to three back-end issues, absorbed by the four-entry
//   command queue. Each result passes the sum stage, the magnitude stage and
//   the divide by five, four quotient bits per stage, on its way to the rsp_
//   port.
//   When rsp_pop stays low, the divider pipeline holds, the command queue
//   fills, and req_full rises; nothing is dropped.
//   Reset clears the row window, the row position and both queues.

module row_box_filter_5tap #(
   parameter int PIXEL_WIDTH = rbf_pkg::PIXEL_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [PIXEL_WIDTH-1:0] req_pixel,
   input  logic                          req_row_end,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [PIXEL_WIDTH-1:0] rsp_mean,
   output logic                          rsp_last_of_row
);

   import rbf_pkg::*;

   localparam int CMD_W = TAPS * PIXEL_WIDTH + 3;
   localparam int RSP_W = PIXEL_WIDTH + 1;

   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_W-1:0] cmd_wr_data, cmd_rd_data;
   logic             out_push, out_full;
   logic [RSP_W-1:0] out_wr_data, out_rd_data;

   rbf_front #(
      .PIXEL_WIDTH (PIXEL_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_pixel   (req_pixel),
      .req_row_end (req_row_end),
      .cmd_push    (cmd_push),
      .cmd_full    (cmd_full),
      .cmd_data    (cmd_wr_data)
   );

   rbf_fifo #(
      .WIDTH      (CMD_W),
      .DEPTH_LOG2 (CMD_DEPTH_LOG2)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .full    (cmd_full),
      .wr_data (cmd_wr_data),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (cmd_rd_data)
   );

   rbf_back #(
      .PIXEL_WIDTH (PIXEL_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rd_data),
      .out_push  (out_push),
      .out_full  (out_full),
      .out_data  (out_wr_data)
   );

   rbf_fifo #(
      .WIDTH      (RSP_W),
      .DEPTH_LOG2 (RSP_DEPTH_LOG2)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .full    (out_full),
      .wr_data (out_wr_data),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (out_rd_data)
   );

   assign rsp_mean        = out_rd_data[PIXEL_WIDTH-1:0];
   assign rsp_last_of_row = out_rd_data[PIXEL_WIDTH];

endmodule

>>> rtl/rbf_fifo.sv
// Small register queue with push/full and pop/empty handshakes.
// Used for the command queue and the result queue; uses no package.
`timescale 1ns / 1ps

module rbf_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]      store_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == (DEPTH_LOG2+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/rbf_front.sv
// Front end of the row box filter: takes pixels, keeps the row window and
// turns each pixel into a command for the back end. Uses rbf_pkg.
`timescale 1ns / 1ps

module rbf_front #(
   parameter int PIXEL_WIDTH = rbf_pkg::PIXEL_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [PIXEL_WIDTH-1:0]       req_pixel,
   input  logic                                req_row_end,
   output logic                                cmd_push,
   input  logic                                cmd_full,
   output logic [rbf_pkg::TAPS*PIXEL_WIDTH+2:0] cmd_data
);

   import rbf_pkg::*;

   localparam int WIN_DEPTH = TAPS - 1;

   logic [PIXEL_WIDTH-1:0] win_ff [WIN_DEPTH];
   logic [PIXEL_WIDTH-1:0] win_in [WIN_DEPTH];
   logic [SEEN_W-1:0]      seen_ff, seen_in;
   logic                   accept;
   logic [1:0]             first_offset;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   // A result exists once two pixels of lookahead are in; a row end always
   // flushes at least one.
   assign cmd_push = accept && (req_row_end || (seen_ff == SEEN_MAX));

   always_comb begin
      case (seen_ff)
         2'd0:    first_offset = 2'd2;
         2'd1:    first_offset = 2'd1;
         default: first_offset = 2'd0;
      endcase
   end

   // Command: row end flag, first window offset to emit, then five taps with
   // the oldest in the low bits.
   assign cmd_data = {req_row_end, first_offset, req_pixel,
                      win_ff[3], win_ff[2], win_ff[1], win_ff[0]};

   always_comb begin
      win_in  = win_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (req_row_end) begin
            for (int j = 0; j < WIN_DEPTH; j++) begin
               win_in[j] = '0;
            end
            seen_in = '0;
         end else begin
            for (int j = 0; j < WIN_DEPTH - 1; j++) begin
               win_in[j] = win_ff[j+1];
            end
            win_in[WIN_DEPTH-1] = req_pixel;
            if (seen_ff != SEEN_MAX) begin
               seen_in = seen_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WIN_DEPTH; j++) begin
            win_ff[j] <= '0;
         end
         seen_ff <= '0;
      end else begin
         win_ff  <= win_in;
         seen_ff <= seen_in;
      end
   end

endmodule

>>> rtl/rbf_back.sv
// Back end of the row box filter: expands each command into one to three
// window sums and divides them by five in a digit pipeline. Uses rbf_pkg.
`timescale 1ns / 1ps

module rbf_back #(
   parameter int PIXEL_WIDTH = rbf_pkg::PIXEL_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_empty,
   output logic                                cmd_pop,
   input  logic [rbf_pkg::TAPS*PIXEL_WIDTH+2:0] cmd_data,
   output logic                                out_push,
   input  logic                                out_full,
   output logic [PIXEL_WIDTH:0]                out_data
);

   import rbf_pkg::*;

   localparam int SUM_W = PIXEL_WIDTH + 3;
   localparam int MAG_W = PIXEL_WIDTH + 2;
   // At least one padding bit keeps the zero extension well formed.
   localparam int NS    = (MAG_W + DIV_DIGIT) / DIV_DIGIT;
   localparam int PAD_W = NS * DIV_DIGIT;

   logic signed [PIXEL_WIDTH-1:0] taps [TAPS];
   logic [1:0]                    head_first;
   logic                          head_row_end;
   logic [1:0]                    cur_off;
   logic                          adv, issue, finish;

   logic                          mid_ff, mid_in;
   logic [1:0]                    off_ff, off_in;

   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic                          sum_last_ff, sum_last_in;
   logic                          sum_valid_ff;

   logic [SUM_W-1:0]              abs_full;

   logic                          stg_valid_ff [NS+1];
   logic                          stg_neg_ff   [NS+1];
   logic                          stg_last_ff  [NS+1];
   logic [PAD_W-1:0]              stg_mag_ff   [NS+1];
   logic [PAD_W-1:0]              stg_quo_ff   [NS+1];
   logic [REM_W-1:0]              stg_rem_ff   [NS+1];

   logic [PIXEL_WIDTH-1:0]        quo_low;
   logic [PIXEL_WIDTH-1:0]        mean;

   always_comb begin
      for (int j = 0; j < TAPS; j++) begin
         taps[j] = cmd_data[j*PIXEL_WIDTH +: PIXEL_WIDTH];
      end
   end
   assign head_first   = cmd_data[TAPS*PIXEL_WIDTH +: 2];
   assign head_row_end = cmd_data[TAPS*PIXEL_WIDTH+2];

   // The whole pipeline holds only while a finished result cannot leave.
   assign adv     = !stg_valid_ff[NS] || !out_full;
   assign cur_off = mid_ff ? off_ff : head_first;
   assign issue   = adv && !cmd_empty;
   // A steady pixel gives one result; a row end walks the offsets up to two.
   assign finish  = !head_row_end || (cur_off == LAST_OFFSET);
   assign cmd_pop = issue && finish;

   always_comb begin
      mid_in = mid_ff;
      off_in = off_ff;
      if (issue) begin
         mid_in = !finish;
         off_in = cur_off + 1'b1;
      end
   end

   // Taps older than the current offset fall outside the window.
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < TAPS; j++) begin
         if (j >= int'(cur_off)) begin
            sum_in = sum_in + SUM_W'(taps[j]);
         end
      end
      sum_last_in = head_row_end && (cur_off == LAST_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff       <= 1'b0;
         off_ff       <= '0;
         sum_valid_ff <= 1'b0;
      end else begin
         mid_ff <= mid_in;
         off_ff <= off_in;
         if (adv) begin
            sum_valid_ff <= issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff      <= sum_in;
         sum_last_ff <= sum_last_in;
      end
   end

   // Magnitude stage: the quotient of the magnitude, negated afterwards,
   // truncates toward zero.
   assign abs_full = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         stg_valid_ff[0] <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_neg_ff[0]  <= sum_ff[SUM_W-1];
         stg_last_ff[0] <= sum_last_ff;
         stg_mag_ff[0]  <= {{(PAD_W-MAG_W){1'b0}}, abs_full[MAG_W-1:0]};
         stg_quo_ff[0]  <= '0;
         stg_rem_ff[0]  <= '0;
      end
   end

   // Each stage takes the top digit of the shifted magnitude.
   for (genvar k = 1; k <= NS; k++) begin : g_div
      logic [REM_W+DIV_DIGIT-1:0] dig_step;

      assign dig_step = div5_step(stg_rem_ff[k-1],
                                  stg_mag_ff[k-1][PAD_W-1 -: DIV_DIGIT]);

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            stg_valid_ff[k] <= stg_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_neg_ff[k]  <= stg_neg_ff[k-1];
            stg_last_ff[k] <= stg_last_ff[k-1];
            stg_mag_ff[k]  <= {stg_mag_ff[k-1][PAD_W-DIV_DIGIT-1:0],
                               {DIV_DIGIT{1'b0}}};
            stg_quo_ff[k]  <= {stg_quo_ff[k-1][PAD_W-DIV_DIGIT-1:0],
                               dig_step[DIV_DIGIT-1:0]};
            stg_rem_ff[k]  <= dig_step[REM_W+DIV_DIGIT-1:DIV_DIGIT];
         end
      end
   end

   assign quo_low  = stg_quo_ff[NS][PIXEL_WIDTH-1:0];
   assign mean     = stg_neg_ff[NS] ? PIXEL_WIDTH'(-quo_low) : quo_low;
   assign out_push = stg_valid_ff[NS] && !out_full;
   assign out_data = {stg_last_ff[NS], mean};

endmodule

>>> test/row_box_filter_5tap_test.sv
// Self-checking testbench for the five-tap row box filter (row_box_filter_5tap).
// Drives pixel rows through the req_ queue port and checks every mean on the rsp_ port.
// Depends on rbf_pkg and the row_box_filter_5tap RTL.
`timescale 1ns / 1ps

module row_box_filter_5tap_test;

   localparam int PW          = rbf_pkg::PIXEL_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 20;
   localparam int ITEM_TARGET = 290;

   typedef struct {
      logic signed [PW-1:0] pixel;
      logic                 row_end;
   } pixel_txn_type;

   typedef struct {
      logic signed [PW-1:0] mean;
      logic                 last_of_row;
   } mean_txn_type;

   typedef enum logic [1:0] {
      POP_ALWAYS, POP_MOSTLY, POP_PERIODIC, POP_SPARSE
   } pop_mode_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_push    = 1'b0;
   logic                 req_full;
   logic signed [PW-1:0] req_pixel   = '0;
   logic                 req_row_end = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop     = 1'b0;
   logic signed [PW-1:0] rsp_mean;
   logic                 rsp_last_of_row;

   pixel_txn_type pixel_backlog[$];
   mean_txn_type  expected_means[$];

   // Filter state as the design should hold it.
   logic signed [PW-1:0] row_taps[4];
   logic [1:0]           row_count;

   logic         pixel_taken = 1'b0;
   logic         draining    = 1'b0;
   int           cycle_count = 0;
   int           mismatches  = 0;
   int           pixels_sent = 0;
   int           rows_sent   = 0;
   int           means_seen  = 0;
   int           burst_left  = 1;
   int           gap_left    = 0;
   int           mode_left   = 0;
   pop_mode_type pop_mode    = POP_ALWAYS;

   row_box_filter_5tap u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pixel       (req_pixel),
      .req_row_end     (req_row_end),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_mean        (rsp_mean),
      .rsp_last_of_row (rsp_last_of_row)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic clear_row_taps();
      for (int i = 0; i < 4; i++) row_taps[i] = '0;
      row_count = '0;
   endtask

   function automatic mean_txn_type make_mean(input int sum, input logic last);
      mean_txn_type m;
      m.mean        = PW'(sum / rbf_pkg::TAPS);
      m.last_of_row = last;
      return m;
   endfunction

   // Works out the means that one accepted pixel releases.
   task automatic filter_pixel(input logic signed [PW-1:0] px, input logic row_end);
      int v[5];
      int sums[3];
      int cnt;
      int first;
      for (int i = 0; i < 4; i++) v[i] = row_taps[i];
      v[4] = px;
      if (!row_end) begin
         if (row_count >= 2'd2)
            expected_means.push_back(make_mean(v[0] + v[1] + v[2] + v[3] + v[4], 1'b0));
         row_taps[0] = row_taps[1];
         row_taps[1] = row_taps[2];
         row_taps[2] = row_taps[3];
         row_taps[3] = px;
         if (row_count < 2'd2) row_count = row_count + 2'd1;
      end else begin
         // The closing pixel flushes the last positions; the taps past the end are zero.
         sums[0] = v[0] + v[1] + v[2] + v[3] + v[4];
         sums[1] = v[1] + v[2] + v[3] + v[4];
         sums[2] = v[2] + v[3] + v[4];
         cnt = int'(row_count) + 1;
         if (cnt > 3) cnt = 3;
         first = 3 - cnt;
         for (int i = 0; i < cnt; i++)
            expected_means.push_back(make_mean(sums[first + i], (i == cnt - 1)));
         clear_row_taps();
      end
   endtask

   task automatic queue_pixel(input logic signed [PW-1:0] px, input logic row_end);
      pixel_txn_type t;
      t.pixel   = px;
      t.row_end = row_end;
      pixel_backlog.push_back(t);
   endtask

   function automatic logic signed [PW-1:0] random_pixel();
      case ($urandom_range(0, 11))
         0:       return {1'b0, {(PW-1){1'b1}}};
         1:       return {1'b1, {(PW-1){1'b0}}};
         2:       return '0;
         3:       return '1;
         default: return PW'($urandom);
      endcase
   endfunction

   task automatic queue_random_row();
      int len;
      case ($urandom_range(0, 3))
         0:       len = $urandom_range(1, 3);
         1, 2:    len = $urandom_range(4, 12);
         default: len = $urandom_range(13, 40);
      endcase
      for (int i = 0; i < len; i++) queue_pixel(random_pixel(), (i == len - 1));
   endtask

   // Sender bursts and the receiver's stall pattern, both changing at the falling edge.
   always @(negedge clock) begin : drive_blk
      pop_mode_type nxt_mode;
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         if (req_push && pixel_taken) begin
            if (pixel_backlog[0].row_end) rows_sent++;
            void'(pixel_backlog.pop_front());
            pixels_sent++;
         end
         // A presented pixel stays on the port until its transaction happens.
         if (!(req_push && !pixel_taken)) begin
            if (gap_left > 0) begin
               req_push <= 1'b0;
               gap_left--;
            end else if (pixel_backlog.size() > 0) begin
               req_push    <= 1'b1;
               req_pixel   <= pixel_backlog[0].pixel;
               req_row_end <= pixel_backlog[0].row_end;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_push <= 1'b0;
            end
         end

         if (mode_left <= 0) begin
            nxt_mode  = pop_mode_type'($urandom_range(0, 3));
            pop_mode  = nxt_mode;
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (draining) begin
            rsp_pop <= 1'b1;
         end else begin
            case (pop_mode)
               POP_ALWAYS:   rsp_pop <= 1'b1;
               POP_MOSTLY:   rsp_pop <= ($urandom_range(0, 3) != 0);
               POP_PERIODIC: rsp_pop <= ((cycle_count % 7) < 3);
               default:      rsp_pop <= ($urandom_range(0, 15) == 0);
            endcase
         end
      end
   end

   // Records accepted pixels and checks each mean against the oldest expectation.
   always @(posedge clock) begin : monitor_blk
      mean_txn_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d means still expected",
                  cycle_count, expected_means.size());
         $display("row_box_filter_5tap test failed");
         $finish;
      end else if (reset) begin
         pixel_taken <= 1'b0;
      end else begin
         pixel_taken <= req_push && !req_full;
         if (req_push && !req_full) filter_pixel(req_pixel, req_row_end);
         if (rsp_pop && !rsp_empty) begin
            means_seen++;
            if (expected_means.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cycle %0d: unexpected mean %0d last_of_row %0b",
                           cycle_count, rsp_mean, rsp_last_of_row);
            end else begin
               want = expected_means.pop_front();
               if (rsp_mean !== want.mean || rsp_last_of_row !== want.last_of_row) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"cycle %0d: mean expected %0d got %0d, ",
                               "last_of_row expected %0b got %0b"},
                              cycle_count, want.mean, rsp_mean,
                              want.last_of_row, rsp_last_of_row);
               end
            end
         end
      end
   end

   initial begin
      clear_row_taps();

      // Directed rows: single pixels at both extremes, short rows, saturated rows.
      queue_pixel(127, 1'b1);
      queue_pixel(-128, 1'b1);
      queue_pixel(5, 1'b0);
      queue_pixel(-5, 1'b1);
      for (int i = 0; i < 3; i++) queue_pixel(127, (i == 2));
      for (int i = 0; i < 4; i++) queue_pixel(-128, (i == 3));
      for (int i = 0; i < 8; i++) queue_pixel((i % 2) ? -128 : 127, (i == 7));
      queue_pixel(-1, 1'b0);
      queue_pixel(1, 1'b0);
      queue_pixel(0, 1'b0);
      queue_pixel(-3, 1'b0);
      queue_pixel(4, 1'b1);

      while (pixel_backlog.size() < ITEM_TARGET) queue_random_row();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pixel_backlog.size() > 0 || expected_means.size() > 0) @(posedge clock);
      draining = 1'b1;
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d pixels in %0d rows and checked %0d means over %0d cycles.",
               pixels_sent, rows_sent, means_seen, cycle_count);
      $display("Sender bursts and receiver stalls varied throughout; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && expected_means.size() == 0) begin
         $display("row_box_filter_5tap test passed");
      end else begin
         $display("row_box_filter_5tap test failed");
      end
      $finish;
   end

endmodule
